// ----- design/psl_pkg.sv -----
// Shared types and constants for the positional sorted list engine.
// Holds request/response payload structs, request and status codes, and cell control types.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package psl_pkg;

	localparam int POS_W      = 7;
	localparam int IDX_OUT_W  = 6;
	localparam int CNT_OUT_W  = 7;
	localparam int KEY_MAX_W  = 64;
	localparam int GROUP_SIZE = 32;
	localparam int GRP_IDX_W  = 5;

	localparam logic [2:0] REQ_INSERT_AT = 3'd0;
	localparam logic [2:0] REQ_DELETE_AT = 3'd1;
	localparam logic [2:0] REQ_LOCATE    = 3'd2;
	localparam logic [2:0] REQ_RETRIEVE  = 3'd3;
	localparam logic [2:0] REQ_SORTED    = 3'd4;
	localparam logic [2:0] REQ_CLEAR     = 3'd5;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_BADPOS   = 2'd1;
	localparam logic [1:0] ST_FULL     = 2'd2;
	localparam logic [1:0] ST_NOTFOUND = 2'd3;

	typedef struct packed {
		logic [2:0]           req_type;
		logic [POS_W-1:0]     position;
		logic [KEY_MAX_W-1:0] name_key;
		logic [7:0]           age;
	} req_t;

	typedef struct packed {
		logic [1:0]           status;
		logic [IDX_OUT_W-1:0] index;
		logic [KEY_MAX_W-1:0] out_name_key;
		logic [7:0]           out_age;
		logic [CNT_OUT_W-1:0] entry_count;
	} rsp_t;

	// Per-cell next-value select.
	typedef enum logic [1:0] {
		SEL_HOLD,
		SEL_LOWER,
		SEL_UPPER,
		SEL_LOAD
	} cell_sel_t;

	typedef struct packed {
		logic match;
		logic le;
	} cell_flags_t;

	typedef struct packed {
		logic                 any_match;
		logic [GRP_IDX_W-1:0] match_idx;
		logic                 any_le;
		logic [GRP_IDX_W-1:0] le_idx;
	} grp_res_t;

endpackage

`default_nettype wire

// ----- design/positional_sorted_list_engine.sv -----
// Positional sorted list engine: an ordered list of up to CAPACITY entries
// (name key, age) kept in a chain of shift cells.
//
// Channels: req (valid/stall) carries one request: insert at, delete at,
// locate, retrieve, sorted insert or clear. rsp (valid/stall) returns one
// response per request with status, index, retrieved entry and entry count.
//
// Timing: an accepted request is held in req_q, compared in every cell in
// S_CMP, reduced by per-group registers (groups of 32 cells), and resolved
// and committed in S_FIN, where the response register is loaded. A new
// request is taken only back in S_IDLE, so requests never overlap.
// If the response register still holds an untaken response, the commit
// cycle waits until rsp_stall drops; the list changes only at commit.
//
// Reset: the entry count goes to zero and no response is pending. Cell
// contents are not cleared; entries above the count are never observed.
// Clear only zeroes the count.
`timescale 1ns / 1ps
`default_nettype none

module positional_sorted_list_engine import psl_pkg::*; #(
	parameter int CAPACITY   = 64,
	parameter int NAME_BYTES = 8
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic req_valid,
	output logic      req_stall,
	input  wire req_t req,
	output logic      rsp_valid,
	input  wire logic rsp_stall,
	output rsp_t      rsp
);

	localparam int KEY_W      = 8 * NAME_BYTES;
	localparam int CNT_W      = $clog2(CAPACITY + 1);
	localparam int CMP_W      = (CNT_W > POS_W) ? CNT_W : POS_W;
	localparam int NUM_GROUPS = (CAPACITY + GROUP_SIZE - 1) / GROUP_SIZE;
	localparam int PAD        = NUM_GROUPS * GROUP_SIZE;

	typedef enum logic [1:0] {
		S_IDLE,
		S_CMP,
		S_FIN
	} state_t;

	state_t           state_q;
	req_t             req_q;
	logic [CNT_W-1:0] cnt_q;
	logic             rsp_valid_q;
	rsp_t             rsp_q;

	// cell row, padded up to a whole number of groups
	cell_flags_t [PAD-1:0]      cell_flags;
	logic [PAD-1:0][KEY_W-1:0]  cell_name;
	logic [PAD-1:0][7:0]        cell_age;
	logic [PAD-1:0]             cell_rd_sel;
	cell_sel_t                  cell_sel [CAPACITY];

	grp_res_t                   grp_res [NUM_GROUPS];
	logic [KEY_W-1:0]           grp_rd_name [NUM_GROUPS];
	logic [7:0]                 grp_rd_age [NUM_GROUPS];

	logic [KEY_W-1:0] key;
	logic [CMP_W-1:0] pos_c;
	logic [CMP_W-1:0] cnt_c;
	logic             full;
	logic             fin_fire;

	// cross-group results
	logic             hit;
	logic [CMP_W-1:0] match_idx;
	logic             le_found;
	logic [CMP_W-1:0] le_idx;
	logic [CMP_W-1:0] sorted_pos;
	logic [KEY_W-1:0] rd_name;
	logic [7:0]       rd_age;

	// commit decision
	logic             do_ins;
	logic             do_del;
	logic [CMP_W-1:0] ins_pos;
	logic [CNT_W-1:0] cnt_next;
	rsp_t             rsp_d;

	assign key      = req_q.name_key[KEY_W-1:0];
	assign pos_c    = CMP_W'(req_q.position);
	assign cnt_c    = CMP_W'(cnt_q);
	assign full     = (cnt_c == CMP_W'(CAPACITY));
	assign fin_fire = (state_q == S_FIN) && (!rsp_valid_q || !rsp_stall);

	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// Cells: each takes its neighbor's entry on a shift, or the new entry at the
	// insert slot. Cell 0 has no lower neighbor; the top cell has no upper one.
	for (genvar i = 0; i < PAD; i++) begin : g_cell
		if (i < CAPACITY) begin : g_live
			logic [KEY_W-1:0] lo_name;
			logic [7:0]       lo_age;
			logic [KEY_W-1:0] up_name;
			logic [7:0]       up_age;

			if (i == 0) begin : g_bot
				assign lo_name = key;
				assign lo_age  = req_q.age;
			end else begin : g_mid_lo
				assign lo_name = cell_name[i-1];
				assign lo_age  = cell_age[i-1];
			end
			if (i == CAPACITY - 1) begin : g_top
				assign up_name = cell_name[i];
				assign up_age  = cell_age[i];
			end else begin : g_mid_up
				assign up_name = cell_name[i+1];
				assign up_age  = cell_age[i+1];
			end

			always_comb begin
				cell_sel[i] = SEL_HOLD;
				if (fin_fire && do_ins) begin
					if (CMP_W'(i) == ins_pos) begin
						cell_sel[i] = SEL_LOAD;
					end else if (CMP_W'(i) > ins_pos) begin
						cell_sel[i] = SEL_LOWER;
					end
				end else if (fin_fire && do_del && (CMP_W'(i) >= pos_c)
					&& (i < CAPACITY - 1)) begin
					cell_sel[i] = SEL_UPPER;
				end
			end

			assign cell_rd_sel[i] = (CMP_W'(i) == pos_c);

			psl_cell #(
				.KEY_W (KEY_W)
			) u_cell (
				.clk        (clk),
				.sel        (cell_sel[i]),
				.lower_name (lo_name),
				.lower_age  (lo_age),
				.upper_name (up_name),
				.upper_age  (up_age),
				.new_name   (key),
				.new_age    (req_q.age),
				.valid      (CMP_W'(i) < cnt_c),
				.flags      (cell_flags[i]),
				.name       (cell_name[i]),
				.age        (cell_age[i])
			);
		end else begin : g_pad
			assign cell_flags[i]  = '0;
			assign cell_name[i]   = '0;
			assign cell_age[i]    = '0;
			assign cell_rd_sel[i] = 1'b0;
		end
	end

	// First reduction level: one registered group per 32 cells.
	for (genvar g = 0; g < NUM_GROUPS; g++) begin : g_grp
		psl_group #(
			.KEY_W (KEY_W)
		) u_group (
			.clk       (clk),
			.flags     (cell_flags[g*GROUP_SIZE +: GROUP_SIZE]),
			.rd_sel    (cell_rd_sel[g*GROUP_SIZE +: GROUP_SIZE]),
			.names     (cell_name[g*GROUP_SIZE +: GROUP_SIZE]),
			.ages      (cell_age[g*GROUP_SIZE +: GROUP_SIZE]),
			.res_q     (grp_res[g]),
			.rd_name_q (grp_rd_name[g]),
			.rd_age_q  (grp_rd_age[g])
		);
	end

	// Second reduction level across groups.
	always_comb begin
		hit       = 1'b0;
		match_idx = '0;
		le_found  = 1'b0;
		le_idx    = '0;
		rd_name   = '0;
		rd_age    = '0;
		// lowest group with a match wins
		for (int g = NUM_GROUPS - 1; g >= 0; g--) begin
			if (grp_res[g].any_match) begin
				hit       = 1'b1;
				match_idx = CMP_W'(g * GROUP_SIZE) + CMP_W'(grp_res[g].match_idx);
			end
		end
		// highest group with a not-greater entry wins
		for (int g = 0; g < NUM_GROUPS; g++) begin
			if (grp_res[g].any_le) begin
				le_found = 1'b1;
				le_idx   = CMP_W'(g * GROUP_SIZE) + CMP_W'(grp_res[g].le_idx);
			end
			rd_name = rd_name | grp_rd_name[g];
			rd_age  = rd_age | grp_rd_age[g];
		end
		sorted_pos = le_found ? (le_idx + CMP_W'(1)) : '0;
	end

	// Resolve the request: status, response fields and the list update.
	always_comb begin
		logic [1:0]       status;
		logic [CMP_W-1:0] idx;
		logic [KEY_W-1:0] out_name;
		logic [7:0]       out_age;

		status   = ST_OK;
		idx      = '0;
		out_name = '0;
		out_age  = '0;
		do_ins   = 1'b0;
		do_del   = 1'b0;
		ins_pos  = '0;
		cnt_next = cnt_q;

		unique case (req_q.req_type)
			REQ_INSERT_AT: begin
				if (pos_c > cnt_c) begin
					status = ST_BADPOS;
				end else if (full) begin
					status = ST_FULL;
				end else begin
					do_ins   = 1'b1;
					ins_pos  = pos_c;
					idx      = pos_c;
					cnt_next = cnt_q + CNT_W'(1);
				end
			end
			REQ_DELETE_AT: begin
				if (pos_c >= cnt_c) begin
					status = ST_BADPOS;
				end else begin
					do_del   = 1'b1;
					cnt_next = cnt_q - CNT_W'(1);
				end
			end
			REQ_LOCATE: begin
				if (hit) begin
					idx = match_idx;
				end else begin
					status = ST_NOTFOUND;
				end
			end
			REQ_RETRIEVE: begin
				if (pos_c >= cnt_c) begin
					status = ST_BADPOS;
				end else begin
					out_name = rd_name;
					out_age  = rd_age;
				end
			end
			REQ_SORTED: begin
				if (full) begin
					status = ST_FULL;
				end else begin
					do_ins   = 1'b1;
					ins_pos  = sorted_pos;
					idx      = sorted_pos;
					cnt_next = cnt_q + CNT_W'(1);
				end
			end
			REQ_CLEAR: begin
				cnt_next = '0;
			end
			default: begin
				status = ST_OK;
			end
		endcase

		rsp_d.status       = status;
		rsp_d.index        = IDX_OUT_W'(idx);
		rsp_d.out_name_key = KEY_MAX_W'(out_name);
		rsp_d.out_age      = out_age;
		rsp_d.entry_count  = CNT_OUT_W'(cnt_next);
	end

	// Sequencer: hold the request through compare and resolve, commit the
	// count and load the response register when it is free.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			req_q       <= '0;
			cnt_q       <= '0;
			rsp_valid_q <= 1'b0;
			rsp_q       <= '0;
		end else begin
			if (fin_fire) begin
				rsp_valid_q <= 1'b1;
				rsp_q       <= rsp_d;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						req_q   <= req;
						state_q <= S_CMP;
					end
				end
				S_CMP: begin
					state_q <= S_FIN;
				end
				S_FIN: begin
					if (fin_fire) begin
						cnt_q   <= cnt_next;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(CAPACITY))
		else $error("entry count above capacity");

	a_cnt_step: assert property (@(posedge clk) disable iff (!arst_n)
		(fin_fire && req_q.req_type != REQ_CLEAR) |=>
		(cnt_q == $past(cnt_q) || cnt_q == $past(cnt_q) + CNT_W'(1)
			|| cnt_q == $past(cnt_q) - CNT_W'(1)))
		else $error("entry count moved by more than one");

	a_rsp_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q == S_FIN))
		else $error("response raised outside the resolve cycle");
`endif

endmodule

`default_nettype wire

// ----- design/psl_cell.sv -----
// One list entry cell: holds a name key and age, shifts to/from its neighbors.
// Produces match (key and age) and not-greater (key) flags against the current request.
// Depends on psl_pkg.
`timescale 1ns / 1ps
`default_nettype none

module psl_cell import psl_pkg::*; #(
	parameter int KEY_W = 64
) (
	input  wire logic             clk,
	input  wire cell_sel_t        sel,
	input  wire logic [KEY_W-1:0] lower_name,
	input  wire logic [7:0]       lower_age,
	input  wire logic [KEY_W-1:0] upper_name,
	input  wire logic [7:0]       upper_age,
	input  wire logic [KEY_W-1:0] new_name,
	input  wire logic [7:0]       new_age,
	input  wire logic             valid,
	output cell_flags_t           flags,
	output logic [KEY_W-1:0]      name,
	output logic [7:0]            age
);

	logic [KEY_W-1:0] name_q;
	logic [7:0]       age_q;

	always_ff @(posedge clk) begin
		unique case (sel)
			SEL_LOWER: begin
				name_q <= lower_name;
				age_q  <= lower_age;
			end
			SEL_UPPER: begin
				name_q <= upper_name;
				age_q  <= upper_age;
			end
			SEL_LOAD: begin
				name_q <= new_name;
				age_q  <= new_age;
			end
			default: begin
				name_q <= name_q;
				age_q  <= age_q;
			end
		endcase
	end

	// compare against the request key and age; only live entries report
	assign flags.match = valid && (name_q == new_name) && (age_q == new_age);
	assign flags.le    = valid && (name_q <= new_name);
	assign name        = name_q;
	assign age         = age_q;

endmodule

`default_nettype wire

// ----- design/psl_group.sv -----
// Registered reduction over one group of cells: first match, last not-greater
// entry and the selected entry's data. Depends on psl_pkg.
`timescale 1ns / 1ps
`default_nettype none

module psl_group import psl_pkg::*; #(
	parameter int KEY_W = 64
) (
	input  wire logic                             clk,
	input  wire cell_flags_t [GROUP_SIZE-1:0]     flags,
	input  wire logic [GROUP_SIZE-1:0]            rd_sel,
	input  wire logic [GROUP_SIZE-1:0][KEY_W-1:0] names,
	input  wire logic [GROUP_SIZE-1:0][7:0]       ages,
	output grp_res_t                              res_q,
	output logic [KEY_W-1:0]                      rd_name_q,
	output logic [7:0]                            rd_age_q
);

	grp_res_t         res_d;
	logic [KEY_W-1:0] rd_name_d;
	logic [7:0]       rd_age_d;

	always_comb begin
		res_d     = '0;
		rd_name_d = '0;
		rd_age_d  = '0;
		// walk down so the lowest match wins
		for (int i = GROUP_SIZE - 1; i >= 0; i--) begin
			if (flags[i].match) begin
				res_d.any_match = 1'b1;
				res_d.match_idx = GRP_IDX_W'(i);
			end
		end
		// walk up so the highest not-greater entry wins
		for (int i = 0; i < GROUP_SIZE; i++) begin
			if (flags[i].le) begin
				res_d.any_le = 1'b1;
				res_d.le_idx = GRP_IDX_W'(i);
			end
			if (rd_sel[i]) begin
				rd_name_d = rd_name_d | names[i];
				rd_age_d  = rd_age_d | ages[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		res_q     <= res_d;
		rd_name_q <= rd_name_d;
		rd_age_q  <= rd_age_d;
	end

endmodule

`default_nettype wire
